>>> design/afd_pkg.sv
package afd_pkg;

	localparam logic [7:0] DELIM_RESET = 8'd126;
	localparam logic [7:0] TYPE_TRANSMIT = 8'd16;
	localparam logic [7:0] TYPE_RECEIVE = 8'd144;
	localparam logic [7:0] SUM_GOOD = 8'hFF;

	// status codes
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_BAD_SUM = 2'd1;
	localparam logic [1:0] ST_ZERO_TYPE = 2'd2;
	localparam logic [1:0] ST_EMPTY = 2'd3;

	// frame kinds
	localparam logic [1:0] KIND_UNKNOWN = 2'd0;
	localparam logic [1:0] KIND_TRANSMIT = 2'd1;
	localparam logic [1:0] KIND_RECEIVE = 2'd2;

	// register index, taken from paddr[2]
	localparam logic REG_DELIM = 1'b0;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       is_type;
		logic       frame_end;
		logic [1:0] status;
		logic [1:0] kind;
	} result_t;

	function automatic logic [1:0] kind_of(input logic [7:0] t);
		if (t == TYPE_TRANSMIT) begin
			return KIND_TRANSMIT;
		end else if (t == TYPE_RECEIVE) begin
			return KIND_RECEIVE;
		end
		return KIND_UNKNOWN;
	endfunction

endpackage

>>> design/afd_cfg.sv
module afd_cfg (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [7:0]  delim
);

	logic [7:0] delim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_q <= afd_pkg::DELIM_RESET;
		end else if (psel && penable && pwrite && paddr[2] == afd_pkg::REG_DELIM) begin
			delim_q <= pwdata[7:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == afd_pkg::REG_DELIM) ? {24'd0, delim_q} : 32'd0;
	assign delim  = delim_q;

endmodule

>>> design/afd_parser.sv
module afd_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [7:0]          delim,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          in_byte,
	input  logic                out_free,
	output logic                push,
	output afd_pkg::result_t    res
);

	localparam logic [2:0] PH_HUNT  = 3'd0;
	localparam logic [2:0] PH_LENHI = 3'd1;
	localparam logic [2:0] PH_LENLO = 3'd2;
	localparam logic [2:0] PH_TYPE  = 3'd3;
	localparam logic [2:0] PH_DATA  = 3'd4;
	localparam logic [2:0] PH_CKSUM = 3'd5;

	logic       valid_s1;
	logic [7:0] byte_s1;

	logic [2:0] phase_q;
	logic       len_zero_q;
	logic [7:0] left_q;
	logic [7:0] sum_q;
	logic [1:0] kind_q;
	logic       type_zero_q;

	logic       produces;
	logic       fire;
	logic [2:0] phase_d;
	logic       len_zero_d;
	logic [7:0] left_d;
	logic [7:0] sum_d;
	logic [1:0] kind_d;
	logic       type_zero_d;
	logic [7:0] sum_next;
	logic [7:0] left_dec;

	assign sum_next = sum_q + byte_s1;
	assign left_dec = left_q - 8'd1;

	always_comb begin
		produces    = 1'b0;
		phase_d     = phase_q;
		len_zero_d  = len_zero_q;
		left_d      = left_q;
		sum_d       = sum_q;
		kind_d      = kind_q;
		type_zero_d = type_zero_q;
		res         = '0;
		res.out_byte = byte_s1;
		unique case (phase_q)
			PH_HUNT: begin
				if (byte_s1 == delim) begin
					phase_d = PH_LENHI;
				end
			end
			PH_LENHI: begin
				phase_d = PH_LENLO;
			end
			PH_LENLO: begin
				len_zero_d  = (byte_s1 == 8'd0);
				left_d      = byte_s1;
				sum_d       = 8'd0;
				kind_d      = afd_pkg::KIND_UNKNOWN;
				type_zero_d = 1'b0;
				phase_d     = (byte_s1 == 8'd0) ? PH_CKSUM : PH_TYPE;
			end
			PH_TYPE: begin
				produces    = 1'b1;
				sum_d       = sum_next;
				kind_d      = afd_pkg::kind_of(byte_s1);
				type_zero_d = (byte_s1 == 8'd0);
				left_d      = left_dec;
				phase_d     = (left_dec == 8'd0) ? PH_CKSUM : PH_DATA;
				res.is_type = 1'b1;
				res.kind    = afd_pkg::kind_of(byte_s1);
			end
			PH_DATA: begin
				produces = 1'b1;
				sum_d    = sum_next;
				left_d   = left_dec;
				phase_d  = (left_dec == 8'd0) ? PH_CKSUM : PH_DATA;
				res.kind = kind_q;
			end
			PH_CKSUM: begin
				produces      = 1'b1;
				sum_d         = sum_next;
				phase_d       = PH_HUNT;
				res.frame_end = 1'b1;
				res.kind      = kind_q;
				if (len_zero_q) begin
					res.status = afd_pkg::ST_EMPTY;
				end else if (sum_next != afd_pkg::SUM_GOOD) begin
					res.status = afd_pkg::ST_BAD_SUM;
				end else if (type_zero_q) begin
					res.status = afd_pkg::ST_ZERO_TYPE;
				end else begin
					res.status = afd_pkg::ST_OK;
				end
			end
			default: begin
				phase_d = PH_HUNT;
			end
		endcase
	end

	// header bytes drain even while the output is full
	assign fire     = valid_s1 && (!produces || out_free);
	assign push     = fire && produces;
	assign in_ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HUNT;
			len_zero_q  <= 1'b0;
			left_q      <= 8'd0;
			sum_q       <= 8'd0;
			kind_q      <= afd_pkg::KIND_UNKNOWN;
			type_zero_q <= 1'b0;
		end else if (fire) begin
			phase_q     <= phase_d;
			len_zero_q  <= len_zero_d;
			left_q      <= left_d;
			sum_q       <= sum_d;
			kind_q      <= kind_d;
			type_zero_q <= type_zero_d;
		end
	end

endmodule

>>> design/afd_out.sv
module afd_out (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  afd_pkg::result_t res,
	output logic             out_free,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [15:0]      m_tdata,
	output logic [2:0]       m_tuser,
	output logic             m_tlast
);

	logic             valid_s2;
	afd_pkg::result_t res_s2;

	assign out_free = !valid_s2 || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (push) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {6'd0, res_s2.status, res_s2.out_byte};
	assign m_tuser  = {res_s2.kind, res_s2.is_type};
	assign m_tlast  = res_s2.frame_end;

endmodule

>>> design/api_frame_deframer.sv
// API frame deframer.
// Slave stream (s_*) carries raw link bytes, one word per byte. The block
// hunts for the start delimiter, skips the length high byte, takes the low
// byte as body length, then passes the type byte and data bytes out on the
// master stream (m_*), one word each. The checksum byte yields a final word
// with m_tlast high and the frame status in m_tdata[9:8].
// Delimiter, length and hunt bytes give no output word.
// APB port: register 0 at address 0 is the start delimiter (reset 0x7E);
// the user must write it only while the stream is idle; not enforced.
// A byte passes the input register, then the output register.
// Throughput: one byte per cycle unless the output stalls; the per-byte
// path is the phase decode plus one 8-bit add and compare between the registers.
// Reset: both registers empty, parser back to hunting, delimiter 0x7E.
// Stall: the output word holds while m_tready is low; one more byte waits
// in the input register, header bytes still drain, and s_tready drops once
// a body or checksum byte is blocked behind the held word.
module api_frame_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] out_byte, [9:8] status, rest zero
	output logic [2:0]  m_tuser,   // [0] is_type, [2:1] kind
	output logic        m_tlast,   // frame_end
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic             out_free;
	logic             push;
	logic [7:0]       delim;
	afd_pkg::result_t res;

	afd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.delim   (delim)
	);

	afd_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.delim    (delim),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_byte  (s_tdata),
		.out_free (out_free),
		.push     (push),
		.res      (res)
	);

	afd_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.res      (res),
		.out_free (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// the type byte is never the end word
	a_type_not_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tlast && m_tuser[0]))
		else $error("type word flagged as frame end");

	// body words carry no status
	a_status_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tlast) |-> (m_tdata[9:8] == afd_pkg::ST_OK))
		else $error("status on a body word");

	// an empty frame never has a kind
	a_empty_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast && m_tdata[9:8] == afd_pkg::ST_EMPTY)
		|-> (m_tuser[2:1] == afd_pkg::KIND_UNKNOWN))
		else $error("empty frame with a kind");

	// a word is only pushed into a free output register
	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> out_free)
		else $error("push into a held output word");

endmodule

>>> tb/testbench.sv
module testbench;

	localparam int WATCHDOG_LIMIT = 3000;  // idle cycles with no handshake anywhere
	localparam int PHASE_BYTES = 370;      // least link bytes per random phase
	localparam int SETTLE_CYCLES = 8;      // header bytes give no word; let them drain

	// parser position, mirrors the block's frame walk
	typedef enum logic [2:0] {
		SEEK_DELIM,
		LEN_HIGH,
		LEN_LOW,
		TYPE_BYTE,
		BODY_BYTE,
		SUM_BYTE
	} parse_t;

	// Predicts the words that come out for every accepted link byte and
	// checks the master-side words against them in order.
	class deframe_scoreboard;
		logic [7:0]       delim;
		parse_t           phase;
		logic [7:0]       body_len;
		logic [7:0]       left;
		logic [7:0]       sum;
		logic [1:0]       kind;
		bit               zero_type;
		afd_pkg::result_t pending[$];
		int               errors;
		int               body_words;
		int               frame_ends;

		function new();
			delim = afd_pkg::DELIM_RESET;
			phase = SEEK_DELIM;
			body_len = 8'd0;
			left = 8'd0;
			sum = 8'd0;
			kind = afd_pkg::KIND_UNKNOWN;
			zero_type = 1'b0;
			errors = 0;
			body_words = 0;
			frame_ends = 0;
		endfunction

		function void take_byte(logic [7:0] b);
			afd_pkg::result_t w;
			w = '0;
			case (phase)
				SEEK_DELIM: begin
					if (b == delim) phase = LEN_HIGH;
				end
				LEN_HIGH: begin
					phase = LEN_LOW;  // high length byte is ignored
				end
				LEN_LOW: begin
					body_len = b;
					left = b;
					sum = 8'd0;
					kind = afd_pkg::KIND_UNKNOWN;
					zero_type = 1'b0;
					phase = (b == 8'd0) ? SUM_BYTE : TYPE_BYTE;
				end
				TYPE_BYTE, BODY_BYTE: begin
					sum += b;
					if (phase == TYPE_BYTE) begin
						if (b == afd_pkg::TYPE_TRANSMIT) kind = afd_pkg::KIND_TRANSMIT;
						else if (b == afd_pkg::TYPE_RECEIVE) kind = afd_pkg::KIND_RECEIVE;
						else kind = afd_pkg::KIND_UNKNOWN;
						zero_type = (b == 8'd0);
						w.is_type = 1'b1;
					end
					w.out_byte = b;
					w.kind = kind;
					pending.push_back(w);
					left -= 8'd1;
					phase = (left == 8'd0) ? SUM_BYTE : BODY_BYTE;
				end
				SUM_BYTE: begin
					sum += b;
					w.out_byte = b;
					w.frame_end = 1'b1;
					w.kind = kind;
					// empty beats bad sum beats zero type
					if (body_len == 8'd0) w.status = afd_pkg::ST_EMPTY;
					else if (sum != afd_pkg::SUM_GOOD) w.status = afd_pkg::ST_BAD_SUM;
					else if (zero_type) w.status = afd_pkg::ST_ZERO_TYPE;
					else w.status = afd_pkg::ST_OK;
					pending.push_back(w);
					phase = SEEK_DELIM;
				end
				default: phase = SEEK_DELIM;
			endcase
		endfunction

		function void report(string field, logic [7:0] want, logic [7:0] got);
			$display("%0t: %s expected %0h got %0h", $time, field, want, got);
			errors++;
		endfunction

		function void check_word(afd_pkg::result_t got);
			afd_pkg::result_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected word, expected none got byte %0h end %b",
					$time, got.out_byte, got.frame_end);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (want.frame_end) frame_ends++;
			else body_words++;
			if (got.out_byte !== want.out_byte)
				report("out_byte", want.out_byte, got.out_byte);
			if (got.is_type !== want.is_type)
				report("is_type", {7'd0, want.is_type}, {7'd0, got.is_type});
			if (got.frame_end !== want.frame_end)
				report("frame_end", {7'd0, want.frame_end}, {7'd0, got.frame_end});
			if (got.status !== want.status)
				report("status", {6'd0, want.status}, {6'd0, got.status});
			if (got.kind !== want.kind)
				report("kind", {6'd0, want.kind}, {6'd0, got.kind});
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;     // [7:0] in_byte
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;            // [7:0] out_byte, [9:8] status
	logic [2:0]  m_tuser;            // [0] is_type, [2:1] kind
	logic        m_tlast;            // frame_end
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = 3'd0;
	logic [31:0] pwdata = 32'd0;
	logic [31:0] prdata;
	logic        pready;

	deframe_scoreboard tracker = new();

	int src_rate = 0;   // 1-in-N chance of a source gap before a byte, 0 = none
	int sink_rate = 0;  // 1-in-N chance of a sink stall burst, 0 = none
	int hold_left = 0;
	int quiet = 0;
	int bytes_sent = 0;
	bit calm = 1'b0;    // last phase runs with no gaps or stalls

	always #5 clk = ~clk;

	api_frame_deframer dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Both handshakes sampled on the edge: note the byte first, then check
	// the word. Latency keeps a byte from producing a word on its own edge.
	always @(posedge clk) begin
		afd_pkg::result_t got;
		if (arst_n) begin
			if (s_tvalid && s_tready) tracker.take_byte(s_tdata);
			if (m_tvalid && m_tready) begin
				got.out_byte = m_tdata[7:0];
				got.is_type = m_tuser[0];
				got.frame_end = m_tlast;
				got.status = m_tdata[9:8];
				got.kind = m_tuser[2:1];
				tracker.check_word(got);
			end
		end
	end

	// Sink side: ready low in stall bursts of random length.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (sink_rate != 0 && $urandom_range(1, sink_rate) == 1) begin
			m_tready <= 1'b0;
			hold_left <= $urandom_range(0, 16);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Watchdog: any handshake on either stream or the register port resets it.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready)) begin
			quiet <= 0;
		end else if (quiet >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog, no word moved for %0d cycles", $time, quiet);
			$display("testbench NOT OK");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	task automatic push_byte(input logic [7:0] b);
		if (src_rate != 0 && $urandom_range(1, src_rate) == 1) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		bytes_sent++;
	endtask

	task automatic apb_access(input bit wr, input logic [7:0] wdata, output logic [31:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {afd_pkg::REG_DELIM, 2'b00};
		pwdata <= {24'd0, wdata};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic check_delim_readback();
		logic [31:0] rd;
		apb_access(1'b0, 8'd0, rd);
		if (rd !== {24'd0, tracker.delim}) begin
			$display("%0t: start_delimiter readback expected %0h got %0h",
				$time, tracker.delim, rd);
			tracker.errors++;
		end
	endtask

	// the bus idles between the write and the readback
	task automatic set_delimiter(input logic [7:0] v);
		logic [31:0] unused;
		apb_access(1'b1, v, unused);
		tracker.delim = v;
		@(posedge clk);
		check_delim_readback();
	endtask

	// Stream goes quiet, every word comes out, then a settle wait for header
	// bytes that are still in the pipe but produce nothing.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (tracker.pending.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Mostly well-formed frames with random content; some hunt noise, some
	// bad sums and some frames cut short so the next byte lands as the checksum.
	task automatic send_random_frame();
		int pick;
		int noise;
		logic [7:0] len;
		logic [7:0] ftype;
		logic [7:0] b;
		logic [7:0] sum;
		logic [7:0] ck;
		bit cut;

		case ($urandom_range(0, 3))
			0: src_rate = 0;
			1: src_rate = 2;
			2: src_rate = 6;
			default: src_rate = 20;
		endcase
		case ($urandom_range(0, 3))
			0: sink_rate = 0;
			1: sink_rate = 3;
			2: sink_rate = 8;
			default: sink_rate = 25;
		endcase
		if (calm) begin
			src_rate = 0;
			sink_rate = 0;
		end

		noise = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
		repeat (noise) push_byte(8'($urandom_range(0, 255)));

		pick = $urandom_range(0, 59);
		if (pick == 0) len = 8'($urandom_range(0, 255));
		else if (pick < 4) len = 8'd0;
		else len = 8'($urandom_range(1, 8));

		case ($urandom_range(0, 4))
			0: ftype = afd_pkg::TYPE_TRANSMIT;
			1: ftype = afd_pkg::TYPE_RECEIVE;
			2: ftype = 8'd0;
			default: ftype = 8'($urandom_range(0, 255));
		endcase

		cut = ($urandom_range(0, 24) == 0);
		push_byte(tracker.delim);
		push_byte(8'($urandom_range(0, 255)));
		push_byte(len);
		sum = 8'd0;
		if (len != 8'd0) begin
			push_byte(ftype);
			sum += ftype;
			for (int i = 1; i < len; i++) begin
				b = 8'($urandom_range(0, 255));
				push_byte(b);
				sum += b;
			end
		end
		if (!cut) begin
			ck = afd_pkg::SUM_GOOD - sum;
			if ($urandom_range(0, 4) == 0) ck = 8'($urandom_range(0, 255));
			push_byte(ck);
		end
	endtask

	task automatic random_phase();
		int start;
		start = bytes_sent;
		while (bytes_sent - start < PHASE_BYTES) send_random_frame();
	endtask

	initial begin
		logic [7:0] directed[$];

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		check_delim_readback();  // reset value

		// hunt noise, transmit frame with good sum, empty frame, receive frame
		// with delimiter in body and bad sum, zero type with good sum
		directed = '{8'h00, 8'hFF,
			afd_pkg::DELIM_RESET, 8'hFF, 8'h02, afd_pkg::TYPE_TRANSMIT, 8'hFF, 8'hF0,
			afd_pkg::DELIM_RESET, 8'h00, 8'h00, 8'hAB,
			afd_pkg::DELIM_RESET, 8'h00, 8'h03, afd_pkg::TYPE_RECEIVE,
			afd_pkg::DELIM_RESET, 8'h00, 8'h00,
			afd_pkg::DELIM_RESET, 8'h00, 8'h01, 8'h00, 8'hFF};
		sink_rate = 4;
		src_rate = 4;
		foreach (directed[i]) push_byte(directed[i]);
		random_phase();

		for (int p = 0; p < 4; p++) begin
			drain();
			case (p)
				0: set_delimiter(8'h00);
				1: set_delimiter(8'hFF);
				default: set_delimiter(8'($urandom_range(0, 255)));
			endcase
			calm = (p == 3);
			random_phase();
		end

		drain();
		if (tracker.pending.size() != 0) begin
			$display("%0t: %0d words never arrived", $time, tracker.pending.size());
			tracker.errors++;
		end

		$display("run: %0d link bytes in, %0d body words and %0d frame ends checked",
			bytes_sent, tracker.body_words, tracker.frame_ends);
		$display("run: delimiters 7e, 00, ff and two random; stalls on both sides but last phase");
		if (tracker.errors == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

endmodule
